### rtl/core/pcsv_pkg.sv
// Shared types and constants of the PI controller with slew-limited valve.
package pcsv_pkg;

  // Width of levels, gains and other register fields.
  localparam int FieldWidth = 16;
  // The error is the difference of two unsigned fields and needs one more bit.
  localparam int ErrWidth   = FieldWidth + 1;
  // Fraction bits dropped after each gain product.
  localparam int FracShift  = 8;
  // Fraction bits dropped from the slew step product.
  localparam int SlewShift  = 9;
  // Full scale of a Q1.15 level.
  localparam logic [FieldWidth-1:0] FULL_SCALE = 16'd32768;

  // Configuration register indexes.
  localparam int CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_PROP_GAIN = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_INT_GAIN  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_TIME_STEP = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_SLEW_RATE = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_INC,
    ST_INTEG,
    ST_PROP,
    ST_DRIVE,
    ST_SLEW
  } state_t;

  // Operand pairs fed to the shared multiplier.
  typedef enum logic [1:0] {
    OP_ERR_TS,
    OP_ERR_KP,
    OP_INT_KI,
    OP_SLEW_TS
  } op_sel_t;

endpackage

### rtl/core/pi_controller_slew_valve_top.sv
// Top level of the PI level controller with a slew-rate-limited valve.
// An accepted measurement steps through MUL_INC, INTEG, PROP, DRIVE and SLEW; SLEW
// loads its result into the output register. A new measurement is taken only in IDLE,
// after the last is through, as the single shared multiplier forms four products per
// tick (error*dt, kp*error, ki*integrator, slew*dt). A full output register stalls
// SLEW until the result is taken. Synchronous reset clears the integrator, the valve
// position and the control state and loads the register defaults.
module pi_controller_slew_valve_top #(
  parameter int INTEG_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [pcsv_pkg::CfgIdxWidth-1:0]     wr_index,
  input  logic [pcsv_pkg::FieldWidth-1:0]      wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pcsv_pkg::FieldWidth-1:0]      measured_level,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pcsv_pkg::FieldWidth-1:0]      drive_command,
  output logic [pcsv_pkg::FieldWidth-1:0]      valve_position,
  output logic                                 integrator_saturated
);
  import pcsv_pkg::*;

  localparam int W  = INTEG_WIDTH;
  localparam int PW = W + ErrWidth;
  localparam int AW = PW + 1;
  localparam int SW = FieldWidth + SlewShift;

  localparam logic signed [PW-1:0] IMAX_EXT = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] IMIN_EXT = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

  // Configuration registers.
  logic [FieldWidth-1:0] setpoint, prop_gain, int_gain, time_step, slew_rate;

  // Sequencer and datapath registers.
  state_t state, state_next;
  op_sel_t op_sel;
  logic signed [ErrWidth-1:0] err;
  logic signed [W-1:0] integrator, integrator_next;
  logic sat, sat_next;
  logic signed [AW-1:0] acc;
  logic [FieldWidth-1:0] drive, drive_next;
  logic [FieldWidth-1:0] valve_pos, valve_pos_next;

  logic signed [W-1:0] mul_a;
  logic signed [ErrWidth-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic out_load;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= 16'd0;
      prop_gain <= 16'd256;
      int_gain  <= 16'd0;
      time_step <= 16'd655;
      slew_rate <= 16'd256;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SETPOINT:  setpoint  <= wr_data;
        REG_PROP_GAIN: prop_gain <= wr_data;
        REG_INT_GAIN:  int_gain  <= wr_data;
        REG_TIME_STEP: time_step <= wr_data;
        REG_SLEW_RATE: slew_rate <= wr_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (op_sel)
      OP_ERR_TS: begin
        mul_a = {{(W-ErrWidth){err[ErrWidth-1]}}, err};
        mul_b = {1'b0, time_step};
      end
      OP_ERR_KP: begin
        mul_a = {{(W-ErrWidth){err[ErrWidth-1]}}, err};
        mul_b = {1'b0, prop_gain};
      end
      OP_INT_KI: begin
        mul_a = integrator;
        mul_b = {1'b0, int_gain};
      end
      default: begin
        mul_a = {{(W-FieldWidth){1'b0}}, slew_rate};
        mul_b = {1'b0, time_step};
      end
    endcase
  end

  pcsv_mul #(
    .A_WIDTH(W)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL_INC;
      ST_MUL_INC: state_next = ST_INTEG;
      ST_INTEG:   state_next = ST_PROP;
      ST_PROP:    state_next = ST_DRIVE;
      ST_DRIVE:   state_next = ST_SLEW;
      ST_SLEW:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    op_sel   = OP_SLEW_TS;
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_MUL_INC: op_sel = OP_ERR_TS;
      ST_INTEG:   op_sel = OP_ERR_KP;
      ST_PROP:    op_sel = OP_INT_KI;
      ST_DRIVE:   op_sel = OP_SLEW_TS;
      ST_SLEW:    out_load = !out_valid || out_ready;
      default:    ;
    endcase
  end

  // Integrator update with saturation, from the error*dt product.
  logic signed [PW-1:0] integ_sum;
  always_comb begin
    integ_sum = $signed({{ErrWidth{integrator[W-1]}}, integrator}) + (prod >>> FracShift);
    integrator_next = integ_sum[W-1:0];
    sat_next = 1'b0;
    if (integ_sum > IMAX_EXT) begin
      integrator_next = IMAX_EXT[W-1:0];
      sat_next = 1'b1;
    end else if (integ_sum < IMIN_EXT) begin
      integrator_next = IMIN_EXT[W-1:0];
      sat_next = 1'b1;
    end
  end

  // Drive: proportional term plus scaled integral term, then clamped to 0..1.
  logic signed [AW-1:0] drive_sum;
  logic signed [AW-1:0] drive_shr;
  always_comb begin
    drive_sum = acc + AW'(prod >>> FracShift);
    drive_shr = drive_sum >>> FracShift;
    if (drive_shr[AW-1]) begin
      drive_next = '0;
    end else if (drive_shr > $signed({{(AW-FieldWidth){1'b0}}, FULL_SCALE})) begin
      drive_next = FULL_SCALE;
    end else begin
      drive_next = drive_shr[FieldWidth-1:0];
    end
  end

  // Valve travel limited to the slew step for this tick.
  logic signed [SW+1:0] step_s;
  logic signed [SW+1:0] diff;
  logic signed [SW+1:0] delta;
  logic signed [SW+1:0] pos_sum;
  always_comb begin
    step_s = {{(SW+2-(2*FieldWidth-SlewShift)){1'b0}}, prod[2*FieldWidth-1:SlewShift]};
    diff = {{(SW-FieldWidth+2){1'b0}}, drive} - {{(SW-FieldWidth+2){1'b0}}, valve_pos};
    if (diff > step_s) begin
      delta = step_s;
    end else if (diff < -step_s) begin
      delta = -step_s;
    end else begin
      delta = diff;
    end
    pos_sum = {{(SW-FieldWidth+2){1'b0}}, valve_pos} + delta;
    valve_pos_next = pos_sum[FieldWidth-1:0];
  end

  // Datapath registers, loaded in the step that produces them.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      err <= $signed({1'b0, setpoint}) - $signed({1'b0, measured_level});
    end
    if (state == ST_INTEG) begin
      sat <= sat_next;
    end
    if (state == ST_PROP) begin
      acc <= {prod[PW-1], prod};
    end
    if (state == ST_DRIVE) begin
      drive <= drive_next;
    end
    if (out_load) begin
      drive_command        <= drive;
      integrator_saturated <= sat;
    end
  end

  // Control state, the integrator and the valve position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      integrator <= '0;
      valve_pos  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INTEG) begin
        integrator <= integrator_next;
      end
      if (out_load) begin
        valve_pos <= valve_pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign valve_position = valve_pos;

endmodule

### rtl/core/pcsv_mul.sv
// Shared signed multiplier with a registered product.
module pcsv_mul #(
  parameter int A_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic signed [A_WIDTH-1:0]                   a,
  input  logic signed [pcsv_pkg::ErrWidth-1:0]        b,
  output logic signed [A_WIDTH+pcsv_pkg::ErrWidth-1:0] prod
);
  import pcsv_pkg::*;

  // One product per cycle; the sequencer picks which cycles it uses.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### bench/testbench.sv
// Self-checking testbench for the PI level controller with a slew-limited valve.
module testbench;
  import pcsv_pkg::*;

  localparam int IntegBits   = 32;
  localparam int LimitCycles = 200000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 200;
  localparam int IdlePercent = 17;
  localparam int MaxPrinted  = 40;

  // Shapes of the random measurement streams.
  typedef enum {
    LEVEL_ANY,
    LEVEL_SPAN,
    LEVEL_LOW,
    LEVEL_HIGH
  } level_mode_t;

  // One controller tick as seen on the output channel.
  typedef struct packed {
    logic [FieldWidth-1:0] drive;
    logic [FieldWidth-1:0] valve;
    logic                  saturated;
  } valve_update_t;

  localparam logic [FieldWidth-1:0] CORNER_LEVELS [14] = '{
    16'h0000, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8001, 16'hAAAA,
    16'h5555, 16'h4000, 16'h0000, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h8000
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CfgIdxWidth-1:0] wr_index = '0;
  logic [FieldWidth-1:0] wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FieldWidth-1:0] measured_level = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FieldWidth-1:0] drive_command;
  logic [FieldWidth-1:0] valve_position;
  logic                  integrator_saturated;

  // Shadow copy of the register file, reset defaults included.
  logic [FieldWidth-1:0] setpoint_q  = 16'd0;
  logic [FieldWidth-1:0] prop_gain_q = 16'd256;
  logic [FieldWidth-1:0] int_gain_q  = 16'd0;
  logic [FieldWidth-1:0] time_step_q = 16'd655;
  logic [FieldWidth-1:0] slew_rate_q = 16'd256;

  // Shadow copy of the loop state.
  longint integ_acc = 0;
  longint valve_acc = 0;

  logic [FieldWidth-1:0] level_samples [$];
  valve_update_t         valve_updates [$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  bit                    quiet_run = 1'b0;
  bit                    hold_go = 1'b0;
  bit                    receiver_hold = 1'b0;

  pi_controller_slew_valve_top #(
    .INTEG_WIDTH(IntegBits)
  ) u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .wr_en               (wr_en),
    .wr_index            (wr_index),
    .wr_data             (wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .measured_level      (measured_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .drive_command       (drive_command),
    .valve_position      (valve_position),
    .integrator_saturated(integrator_saturated)
  );

  // Free-running clock, period 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter with a hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Advances the shadow loop by one tick and returns what the block should output.
  function automatic valve_update_t advance_loop(input logic [FieldWidth-1:0] level);
    valve_update_t upd;
    longint err, sum, drive, step, delta, imax, imin;
    bit sat;
    imax = (longint'(1) <<< (IntegBits - 1)) - 1;
    imin = -imax - 1;
    sat = 1'b0;
    err = longint'(setpoint_q) - longint'(level);

    // Integrate error*dt, floor to Q.23, and clamp at the accumulator limits.
    sum = integ_acc + ((err * longint'(time_step_q)) >>> FracShift);
    if (sum > imax) begin
      sum = imax;
      sat = 1'b1;
    end
    if (sum < imin) begin
      sum = imin;
      sat = 1'b1;
    end
    integ_acc = sum;

    // Proportional plus integral term, floored to Q.15 and clamped to 0..1.
    drive = err * longint'(prop_gain_q) + ((integ_acc * longint'(int_gain_q)) >>> FracShift);
    drive = drive >>> FracShift;
    if (drive < 0) drive = 0;
    if (drive > longint'(FULL_SCALE)) drive = longint'(FULL_SCALE);

    // The valve follows the drive by at most one slew step per tick.
    step = (longint'(slew_rate_q) * longint'(time_step_q)) >>> SlewShift;
    delta = drive - valve_acc;
    if (delta > step) delta = step;
    if (delta < -step) delta = -step;
    valve_acc = valve_acc + delta;

    upd.drive = FieldWidth'(drive);
    upd.valve = FieldWidth'(valve_acc);
    upd.saturated = sat;
    return upd;
  endfunction

  function automatic logic [FieldWidth-1:0] pick_level(input level_mode_t mode);
    case (mode)
      LEVEL_ANY:  return FieldWidth'($urandom_range(16'hFFFF));
      LEVEL_LOW:  return FieldWidth'($urandom_range(2047));
      LEVEL_HIGH: return FieldWidth'($urandom_range(16'hFFFF, 16'hC000));
      default: begin
        // Mostly in range, now and then above full scale.
        if ($urandom_range(99) < 90) return FieldWidth'($urandom_range(FULL_SCALE));
        return FieldWidth'($urandom_range(16'hFFFF, FULL_SCALE + 1));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // One register write; the shadow copy follows at once since the block is idle.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [FieldWidth-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_SETPOINT:  setpoint_q = val;
      REG_PROP_GAIN: prop_gain_q = val;
      REG_INT_GAIN:  int_gain_q = val;
      REG_TIME_STEP: time_step_q = val;
      REG_SLEW_RATE: slew_rate_q = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [FieldWidth-1:0] sp, input logic [FieldWidth-1:0] kp,
                               input logic [FieldWidth-1:0] ki, input logic [FieldWidth-1:0] ts,
                               input logic [FieldWidth-1:0] slew);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INT_GAIN, ki);
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_SLEW_RATE, slew);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // Waits until every queued measurement is taken and every tick has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (level_samples.size() != 0 || in_valid || valve_updates.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input level_mode_t mode);
    @(negedge clk);
    for (int i = 0; i < count; i++) level_samples.push_back(pick_level(mode));
    wait_drained();
  endtask

  // Input driver: offers queued measurements and idles at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // Transaction still pending: hold valid and payload.
    end else if (level_samples.size() != 0 && (quiet_run || $urandom_range(99) >= IdlePercent)) begin
      in_valid <= 1'b1;
      measured_level <= level_samples.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output ready: random stalls, none during the quiet run, and the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_hold && (quiet_run || $urandom_range(99) >= IdlePercent);
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  initial begin
    wait (hold_go);
    @(negedge clk);
    receiver_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk);
    receiver_hold = 1'b0;
  end

  // Monitor: predicts on each accepted measurement and checks each accepted tick.
  always @(posedge clk) begin
    valve_update_t want;
    if (!rst) begin
      if (in_valid && in_ready) valve_updates.push_back(advance_loop(measured_level));
      if (out_valid && out_ready) begin
        if (valve_updates.size() == 0) begin
          report_mismatch("output transaction with no measurement pending");
        end else begin
          want = valve_updates.pop_front();
          if (drive_command !== want.drive)
            report_mismatch($sformatf("drive_command %0d, predicted %0d", drive_command,
                                      want.drive));
          if (valve_position !== want.valve)
            report_mismatch($sformatf("valve_position %0d, predicted %0d", valve_position,
                                      want.valve));
          if (integrator_saturated !== want.saturated)
            report_mismatch($sformatf("integrator_saturated %0b, predicted %0b",
                                      integrator_saturated, want.saturated));
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    logic [FieldWidth-1:0] sp;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Writes to unused indexes must leave every register alone.
    for (int i = REG_SLEW_RATE + 1; i < (1 << CfgIdxWidth); i++)
      write_reg(CfgIdxWidth'(i), FieldWidth'($urandom));
    @(posedge clk);
    wr_en <= 1'b0;

    // Corner levels under the reset defaults.
    @(negedge clk);
    foreach (CORNER_LEVELS[i]) level_samples.push_back(CORNER_LEVELS[i]);
    wait_drained();

    // Zero time step and zero gains: integrator and valve stay put.
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(40, LEVEL_ANY);

    // Every register at its maximum, setpoint above full scale.
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(60, LEVEL_ANY);

    // Drive the integrator into its upper limit without any idling.
    @(negedge clk);
    quiet_run = 1'b1;
    load_settings(16'hFFFF, 16'h0100, 16'h0400, 16'hFFFF, 16'hFFFF);
    run_phase(150, LEVEL_LOW);
    quiet_run = 1'b0;

    // Swing to the lower limit, with the long receiver hold-off on the way.
    load_settings(16'h0000, 16'h0080, 16'h0200, 16'hFFFF, 16'h0800);
    hold_go = 1'b1;
    run_phase(320, LEVEL_HIGH);

    // Random settings with levels around the working range, and any level in the last round.
    for (int p = 0; p < 4; p++) begin
      sp = ($urandom_range(99) < 80) ? FieldWidth'($urandom_range(FULL_SCALE))
                                      : FieldWidth'($urandom);
      load_settings(sp, FieldWidth'($urandom), FieldWidth'($urandom_range(4096)),
                    FieldWidth'($urandom), FieldWidth'($urandom));
      run_phase(65, (p == 3) ? LEVEL_ANY : LEVEL_SPAN);
    end

    if (valve_updates.size() != 0) report_mismatch("ticks still expected at the end");
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
